// ===== rtl/core/assert_macros.svh =====
// Assertion helpers. Each one expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds in the same cycle as the trigger.
`define KVT_ASSERT_NOW(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// The condition holds in the cycle after the trigger.
`define KVT_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ===== rtl/core/kvt_pkg.sv =====
`timescale 1ns / 1ps
package kvt_pkg;

	localparam int KVT_ENTRIES = 16;
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;

	localparam logic [1:0] OP_CREATE = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_UPDATE = 2'd2;
	localparam logic [1:0] OP_DELETE = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [1:0]               opcode;
		logic signed [KEY_W-1:0]  req_key;
		logic signed [VAL_W-1:0]  req_value;
	} kvt_req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0]  read_value;
		logic [1:0]               status;
	} kvt_rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic       latch_req;
		logic       idx_clr;
		logic       idx_inc;
		logic       rd_en;
		logic       rd_next;
		logic       wr_en;
		logic       wr_tail;
		logic       wr_shift;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       st_load;
		logic [1:0] st_code;
		logic       rv_load;
		logic       out_load;
	} kvt_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] op;
		logic       at_end;
		logic       full;
		logic       last;
		logic       hit;
		logic       out_free;
	} kvt_sts_t;

endpackage

// ===== rtl/core/kvt_ram.sv =====
`timescale 1ns / 1ps
module kvt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/kvt_ctrl.sv =====
`timescale 1ns / 1ps
module kvt_ctrl
	import kvt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  kvt_sts_t sts,
	output kvt_cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DISP   = 3'd1;
	localparam logic [2:0] S_CREATE = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_CMP    = 3'd4;
	localparam logic [2:0] S_SHRD   = 3'd5;
	localparam logic [2:0] S_SHWR   = 3'd6;
	localparam logic [2:0] S_RESP   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch_req = 1'b1;
					cmd.idx_clr   = 1'b1;
					state_d       = S_DISP;
				end
			end
			S_DISP: begin
				state_d = (sts.op == OP_CREATE) ? S_CREATE : S_SCAN;
			end
			S_CREATE: begin
				cmd.st_load = 1'b1;
				if (sts.full) begin
					cmd.st_code = ST_FULL;
				end else begin
					cmd.st_code = ST_OK;
					cmd.wr_en   = 1'b1;
					cmd.wr_tail = 1'b1;
					cmd.cnt_inc = 1'b1;
				end
				state_d = S_RESP;
			end
			S_SCAN: begin
				if (sts.at_end) begin
					cmd.st_load = 1'b1;
					cmd.st_code = ST_NOT_FOUND;
					state_d     = S_RESP;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = S_CMP;
				end
			end
			S_CMP: begin
				if (sts.hit) begin
					cmd.st_load = 1'b1;
					cmd.st_code = ST_OK;
					unique case (sts.op)
						OP_READ: begin
							cmd.rv_load = 1'b1;
							state_d     = S_RESP;
						end
						OP_UPDATE: begin
							cmd.wr_en = 1'b1;
							state_d   = S_RESP;
						end
						OP_DELETE: begin
							state_d = S_SHRD;
						end
						default: begin
							state_d = S_RESP;
						end
					endcase
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_SCAN;
				end
			end
			S_SHRD: begin
				if (sts.last) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_RESP;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_next = 1'b1;
					state_d     = S_SHWR;
				end
			end
			S_SHWR: begin
				cmd.wr_en    = 1'b1;
				cmd.wr_shift = 1'b1;
				cmd.idx_inc  = 1'b1;
				state_d      = S_SHRD;
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/kvt_dp.sv =====
`timescale 1ns / 1ps
module kvt_dp
	import kvt_pkg::*;
#(
	parameter int ENTRIES = KVT_ENTRIES
) (
	input  logic     clk,
	input  logic     arst_n,
	input  kvt_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output kvt_rsp_t rsp,
	input  kvt_cmd_t cmd,
	output kvt_sts_t sts
);

	localparam int CW = $clog2(ENTRIES + 1);
	localparam int AW = $clog2(ENTRIES);
	localparam int DW = KEY_W + VAL_W;
	localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

	kvt_req_t               req_q;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          idx_q;
	logic [CW-1:0]          idx_nxt;
	logic [1:0]             st_q;
	logic signed [VAL_W-1:0] rv_q;
	logic                   rsp_valid_q;
	kvt_rsp_t               rsp_q;

	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [DW-1:0]          ram_wdata;
	logic [AW-1:0]          ram_raddr;
	logic [DW-1:0]          ram_rdata;

	assign idx_nxt = idx_q + 1'b1;

	// word layout: key in the upper half, value in the lower
	assign ram_we    = cmd.wr_en;
	assign ram_waddr = cmd.wr_tail ? cnt_q[AW-1:0] : idx_q[AW-1:0];
	assign ram_wdata = cmd.wr_shift ? ram_rdata : {req_q.req_key, req_q.req_value};
	assign ram_raddr = cmd.rd_next ? idx_nxt[AW-1:0] : idx_q[AW-1:0];

	kvt_ram #(
		.WIDTH(DW),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.rd_en),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign sts.op       = req_q.opcode;
	assign sts.at_end   = (idx_q == cnt_q);
	assign sts.full     = (cnt_q == FULL_CNT);
	assign sts.last     = (idx_nxt >= cnt_q);
	assign sts.hit      = (ram_rdata[DW-1:VAL_W] == req_q.req_key);
	assign sts.out_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_nxt;
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			req_q <= req;
			rv_q  <= '0;
		end else if (cmd.rv_load) begin
			rv_q <= $signed(ram_rdata[VAL_W-1:0]);
		end
		if (cmd.st_load) begin
			st_q <= cmd.st_code;
		end
		if (cmd.out_load) begin
			rsp_q.read_value <= rv_q;
			rsp_q.status     <= st_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/core/key_value_table_core.sv =====
// Bounded key-value table kept in insertion order, ENTRIES deep. Each request word carries an
// opcode (create, read, update, delete), a key and a value, and yields exactly one response
// word with a status (ok, not found, full) and, for a successful read, the stored value;
// read_value is zero for any other outcome. Create appends at the tail and allows duplicate
// keys; read, update and delete act on the earliest entry with a matching key, and delete
// shifts the later entries down one slot so their order is kept. One request is in work at a
// time; req_ready is high only while the engine is idle, but a finished response sits in an
// output register, so the next request is taken while the previous response waits. Create
// passes through dispatch, append (or a full status) and respond; a search probes slots from
// the head, each probe a registered read of the single table RAM followed by a compare, and a
// delete then moves every later entry down with a read-then-write pair. The table contents
// need no clearing after reset; only the fill count, scan index, response valid flag and
// controller state are reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module key_value_table_core
	import kvt_pkg::*;
#(
	parameter int ENTRIES = KVT_ENTRIES
) (
	input  logic     clk,
	input  logic     arst_n,
	// request channel
	input  logic     req_valid,
	output logic     req_ready,
	input  kvt_req_t req,
	// response channel
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output kvt_rsp_t rsp
);

	kvt_cmd_t cmd;  // controller commands
	kvt_sts_t sts;  // datapath flags

	// sequencer: dispatch, scan, compact, respond
	kvt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// table RAM, fill count, scan index and response register
	kvt_dp #(
		.ENTRIES(ENTRIES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cmd      (cmd),
		.sts      (sts)
	);

	// a word taken means the engine is busy the next cycle
	`KVT_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready,
		"request accepted but engine still idle")
	// never append past the last slot
	`KVT_ASSERT_NOW(a_no_overflow, cmd.cnt_inc, !sts.full, "append on a full table")
	// delete only retires an entry that the scan found
	`KVT_ASSERT_NOW(a_dec_in_range, cmd.cnt_dec, !sts.at_end, "delete with no live entry")
	// only a successful read carries a value
	`KVT_ASSERT_NOW(a_zero_value, rsp_valid && rsp.status != ST_OK, rsp.read_value == '0,
		"nonzero value on a failed request")

endmodule
